// ===== rtl/ac3ssr_pkg.sv =====
// ---------------------------------------------------------------------------
// ac3ssr_pkg
// Shared types and constants of the AC-3 sync word search and repair block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ac3ssr_pkg;

    // sync word as it stands in a correctly ordered stream, and byte-swapped
    localparam logic [15:0] SYNC_CODE = 16'h0B77;
    localparam logic [15:0] SWAP_WORD = 16'h770B;

    // header checks
    localparam logic [12:0] MIN_FRAME_WORDS = 13'd7;
    localparam int unsigned MIN_REMAINING   = 7;

    // configuration register reset values
    localparam logic [12:0] MAX_WORDS_RST = 13'd3840;
    localparam logic [4:0]  MAX_SID_RST   = 5'd16;

    // configuration port geometry
    localparam int unsigned CFG_DATA_W = 13;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        CFG_MAX_WORDS = 1'b0,
        CFG_MAX_SID   = 1'b1
    } t_cfg_idx;

    // per packet verdict codes
    typedef enum logic [1:0] {
        V_ALIGNED = 2'd0,
        V_REALIGN = 2'd1,
        V_SWAP    = 2'd2,
        V_INVALID = 2'd3
    } t_verdict;

    // six byte search window, index 0 is the oldest byte
    typedef logic [5:0][7:0] t_window;

    // packet status handed to the verdict logic on the last byte
    typedef struct packed {
        logic        two_bytes;
        logic [15:0] lead_pair;
        logic        found;
    } t_pkt_status;

endpackage

`default_nettype wire

// ===== rtl/ac3_sync_search_repair.sv =====
// ---------------------------------------------------------------------------
// ac3_sync_search_repair
// AC-3 sync word check and repair verdict, one verdict per packet.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall) carries the bytes of a packet in
//   order, each with the packet length and a last-byte mark. Output channel
//   (o_out_valid / i_out_stall) carries one verdict and sync offset for each
//   packet, raised in the cycle after its last byte is taken.
//   Throughput is one byte per clock while the input is not stalled: each
//   byte shifts the six byte window register and the candidate header check
//   runs in the same cycle, so a byte can follow in every such cycle. The
//   verdict is held in the result register.
//   The result register parts the two channels: bytes keep flowing while a
//   verdict waits, and input is stalled only while a verdict is held and the
//   receiver stalls it.
//   Configuration writes (max frame words, max stream id) take effect at the
//   next edge; users must make them while no packet is in flight, unchecked.
//   Reset clears the packet state and the result valid flag, and loads the
//   configuration defaults of 3840 words and stream id 16. No clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ac3_sync_search_repair #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  ac3ssr_pkg::t_cfg_idx   i_cfg_index,
    input  logic [ac3ssr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // byte input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_data_byte,
    input  logic [LENGTH_BITS-1:0] i_packet_length,
    input  logic                   i_last_byte,
    // verdict output channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_verdict,
    output logic [15:0]            o_align_offset
);
    import ac3ssr_pkg::*;

    localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

    // configuration
    logic [12:0] r_max_words;
    logic [4:0]  r_max_sid;

    // packet state
    t_window                r_window,    n_window;
    logic [LENGTH_BITS-1:0] r_pos,       n_pos;
    logic [7:0]             r_lead_hi,   n_lead_hi;
    logic [7:0]             r_lead_lo,   n_lead_lo;
    logic                   r_found,     n_found;
    logic [LENGTH_BITS-1:0] r_found_off, n_found_off;

    // result register
    logic        r_out_valid;
    t_verdict    r_verdict;
    logic [15:0] r_align_offset;

    logic                   accept;
    logic                   cand_ok;
    logic [LENGTH_BITS-1:0] cand_off;
    t_pkt_status            status;
    t_verdict               verdict;
    logic [15:0]            align_offset;

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_words <= MAX_WORDS_RST;
            r_max_sid   <= MAX_SID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_WORDS: r_max_words <= i_cfg_data[12:0];
                CFG_MAX_SID:   r_max_sid   <= i_cfg_data[4:0];
                default:       r_max_words <= r_max_words;
            endcase
        end
    end

    // candidate at the offset whose window the current byte completes
    assign n_window = {i_data_byte, r_window[5:1]};
    assign cand_off = r_pos - LENGTH_BITS'(5);

    ac3ssr_cand #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_cand (
        .i_window    (n_window),
        .i_offset    (cand_off),
        .i_length    (i_packet_length),
        .i_max_words (r_max_words),
        .i_max_sid   (r_max_sid),
        .o_ok        (cand_ok)
    );

    // state update for one byte
    always_comb begin
        n_lead_hi   = r_lead_hi;
        n_lead_lo   = r_lead_lo;
        n_found     = r_found;
        n_found_off = r_found_off;
        n_pos       = r_pos;
        if (r_pos == '0) begin
            n_lead_hi = i_data_byte;
        end
        if (r_pos == LENGTH_BITS'(1)) begin
            n_lead_lo = i_data_byte;
        end
        if ((r_pos >= LENGTH_BITS'(5)) && !r_found && cand_ok) begin
            n_found     = 1'b1;
            n_found_off = cand_off;
        end
        if (r_pos != POS_MAX) begin
            n_pos = r_pos + LENGTH_BITS'(1);
        end
    end

    // status seen by the verdict, including the current byte
    assign status.two_bytes = (r_pos >= LENGTH_BITS'(1)) &&
                              (i_packet_length >= LENGTH_BITS'(2));
    assign status.lead_pair = {n_lead_hi, n_lead_lo};
    assign status.found     = n_found;

    ac3ssr_verdict #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_verdict (
        .i_status       (status),
        .i_found_offset (n_found_off),
        .o_verdict      (verdict),
        .o_align_offset (align_offset)
    );

    // packet state registers, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_pos       <= '0;
            r_lead_hi   <= '0;
            r_lead_lo   <= '0;
            r_found     <= 1'b0;
            r_found_off <= '0;
        end else if (accept) begin
            if (i_last_byte) begin
                r_window    <= '0;
                r_pos       <= '0;
                r_lead_hi   <= '0;
                r_lead_lo   <= '0;
                r_found     <= 1'b0;
                r_found_off <= '0;
            end else begin
                r_window    <= n_window;
                r_pos       <= n_pos;
                r_lead_hi   <= n_lead_hi;
                r_lead_lo   <= n_lead_lo;
                r_found     <= n_found;
                r_found_off <= n_found_off;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_verdict      <= verdict;
            r_align_offset <= align_offset;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_align_offset = r_align_offset;

endmodule

`default_nettype wire

// ===== rtl/ac3ssr_cand.sv =====
// ---------------------------------------------------------------------------
// ac3ssr_cand
// Header check of one sync word candidate held in the six byte window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ac3ssr_cand #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  ac3ssr_pkg::t_window i_window,
    input  logic [LENGTH_BITS-1:0] i_offset,
    input  logic [LENGTH_BITS-1:0] i_length,
    input  logic [12:0]            i_max_words,
    input  logic [4:0]             i_max_sid,
    output logic                   o_ok
);
    import ac3ssr_pkg::*;

    // wide enough for offset plus twice a 13-bit size without overflow
    localparam int unsigned SUM_W = ((LENGTH_BITS > 14) ? LENGTH_BITS : 14) + 1;

    logic [12:0]        words;
    logic [4:0]         sid;
    logic               sync_hit;
    logic               size_ok;
    logic               sid_ok;
    logic               room_ok;
    logic               span_ok;
    logic [LENGTH_BITS:0] off_plus_min;
    logic [SUM_W-1:0]   off_plus_span;

    // size field as packed in the file, and the stream id
    assign words = {i_window[2][1:0], i_window[3], i_window[4][7:5]};
    assign sid   = i_window[5][7:3];

    assign sync_hit = ({i_window[0], i_window[1]} == SYNC_CODE);
    assign size_ok  = (words >= MIN_FRAME_WORDS) && (words <= i_max_words);
    assign sid_ok   = (sid <= i_max_sid);

    // remaining bytes from the candidate offset
    assign off_plus_min  = {1'b0, i_offset} + (LENGTH_BITS+1)'(MIN_REMAINING);
    assign room_ok       = (off_plus_min <= {1'b0, i_length});
    assign off_plus_span = SUM_W'(i_offset) + SUM_W'({words, 1'b0});
    assign span_ok       = (off_plus_span <= SUM_W'(i_length));

    assign o_ok = sync_hit && size_ok && sid_ok && room_ok && span_ok;

endmodule

`default_nettype wire

// ===== rtl/ac3ssr_verdict.sv =====
// ---------------------------------------------------------------------------
// ac3ssr_verdict
// Priority selection of the packet verdict and its sync offset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ac3ssr_verdict #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  ac3ssr_pkg::t_pkt_status i_status,
    input  logic [LENGTH_BITS-1:0]  i_found_offset,
    output ac3ssr_pkg::t_verdict    o_verdict,
    output logic [15:0]             o_align_offset
);
    import ac3ssr_pkg::*;

    logic [31:0] offset_wide;

    // offset brought to a fixed width, the low sixteen bits are reported
    assign offset_wide = 32'(i_found_offset);

    // aligned wins over a found candidate, which wins over byte-swap
    always_comb begin
        o_verdict      = V_INVALID;
        o_align_offset = 16'd0;
        if (i_status.two_bytes && (i_status.lead_pair == SYNC_CODE)) begin
            o_verdict = V_ALIGNED;
        end else if (i_status.found) begin
            o_verdict      = V_REALIGN;
            o_align_offset = offset_wide[15:0];
        end else if (i_status.two_bytes && (i_status.lead_pair == SWAP_WORD)) begin
            o_verdict = V_SWAP;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ac3ssr_chk.sv =====
// ---------------------------------------------------------------------------
// ac3ssr_chk
// Port level checks of the sync search block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ac3ssr_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic        i_last_byte,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  o_verdict,
    input  logic [15:0] o_align_offset
);
    import ac3ssr_pkg::*;

    // a held verdict stays put while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_verdict) && $stable(o_align_offset)))
        else $error("verdict changed while stalled");

    // a last byte taken gives a verdict in the next cycle
    a_last_gives_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_last_byte) |=> o_out_valid)
        else $error("no verdict after last byte");

    // a new verdict only follows a last byte
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall && i_last_byte))
        else $error("verdict without last byte");

    // offset only reported for a realign verdict
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_verdict != V_REALIGN)) |-> (o_align_offset == 16'd0))
        else $error("sync offset set on a verdict other than realign");

    // input is stalled only behind a held verdict
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held verdict");

endmodule

bind ac3_sync_search_repair ac3ssr_chk u_ac3ssr_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_last_byte    (i_last_byte),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_verdict      (o_verdict),
    .o_align_offset (o_align_offset)
);

`default_nettype wire
